>>> sv/bounded_sorted_deque_defines.svh
// Assertion macros shared by the design files
`ifndef BOUNDED_SORTED_DEQUE_DEFINES_SVH
`define BOUNDED_SORTED_DEQUE_DEFINES_SVH

// Antecedent implies consequent in the same cycle
`define BSD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle
`define BSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/bsd_pkg.sv
`timescale 1ns / 1ps
package bsd_pkg;
   localparam int Capacity = 16;
   localparam int CountW = $clog2(Capacity + 1);
   localparam int IdxW = $clog2(Capacity);

   typedef enum logic [2:0] {
      OP_PUSH_FRONT    = 3'd0,
      OP_PUSH_BACK     = 3'd1,
      OP_SORTED_INSERT = 3'd2,
      OP_POP_FRONT     = 3'd3,
      OP_POP_BACK      = 3'd4,
      OP_REMOVE        = 3'd5,
      OP_CONTAINS      = 3'd6,
      OP_NONE          = 3'd7
   } op_type;

   // controller -> datapath
   typedef struct packed {
      logic   capture;  // latch request word
      logic   execute;  // apply the latched operation to the cells
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic   done;
   } stat_type;
endpackage

>>> sv/bsd_datapath.sv
`timescale 1ns / 1ps
`include "bounded_sorted_deque_defines.svh"
module bsd_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  bsd_pkg::cmd_type                cmd,
   output bsd_pkg::stat_type               stat,
   input  logic [2:0]                      req_operation,
   input  logic signed [31:0]              req_value,
   output logic                            res_ok,
   output logic signed [31:0]              res_popped,
   output logic [bsd_pkg::CountW-1:0]      res_count
);
   import bsd_pkg::*;

   logic [31:0]       cell_ff [Capacity];
   logic [31:0]       cell_in [Capacity];
   logic [CountW-1:0] count_ff, count_in;
   logic [2:0]        op_ff;
   logic [31:0]       val_ff;
   logic              ok_ff, ok_in;
   logic [31:0]       pop_ff, pop_in;
   logic              done_ff;

   // per-cell compare results
   logic [Capacity-1:0] live, eq, gt, ins_here, rem_at, rem_first, gt_first;
   logic                full, empty, found;

   always_comb begin
      for (int i = 0; i < Capacity; i++) begin
         live[i] = (CountW'(i) < count_ff);
         eq[i]   = live[i] && (cell_ff[i] == val_ff);
         gt[i]   = live[i] && ($signed(cell_ff[i]) > $signed(val_ff));
      end
      // first match and first greater cell, found by prefix
      rem_first[0] = eq[0];
      gt_first[0]  = gt[0];
      for (int i = 1; i < Capacity; i++) begin
         rem_first[i] = eq[i] && !(|(eq & ((Capacity'(1) << i) - Capacity'(1))));
         gt_first[i]  = gt[i] && !(|(gt & ((Capacity'(1) << i) - Capacity'(1))));
      end
   end

   assign full  = (count_ff >= CountW'(Capacity));
   assign empty = (count_ff == '0);
   assign found = |eq;

   always_comb begin
      // insertion position: cells at or after pos shift back
      logic [Capacity-1:0] shift_back, shift_fwd;
      logic                do_ins, do_rem;
      shift_back = '0;
      shift_fwd  = '0;
      do_ins     = 1'b0;
      do_rem     = 1'b0;
      ok_in      = 1'b0;
      pop_in     = '0;
      count_in   = count_ff;
      ins_here   = '0;
      rem_at     = '0;
      case (op_type'(op_ff))
         OP_PUSH_FRONT: begin
            do_ins   = !full;
            ins_here[0] = 1'b1;
         end
         OP_PUSH_BACK: begin
            do_ins = !full;
            for (int i = 0; i < Capacity; i++)
               ins_here[i] = (CountW'(i) == count_ff);
         end
         OP_SORTED_INSERT: begin
            do_ins = !full;
            // before the first greater value, else at the back
            for (int i = 0; i < Capacity; i++)
               ins_here[i] = gt_first[i] || (!(|gt) && CountW'(i) == count_ff);
         end
         OP_POP_FRONT: begin
            do_rem    = !empty;
            rem_at[0] = 1'b1;
         end
         OP_POP_BACK: begin
            do_rem = !empty;
            for (int i = 0; i < Capacity; i++)
               rem_at[i] = (CountW'(i + 1) == count_ff);
         end
         OP_REMOVE: begin
            do_rem = found;
            rem_at = rem_first;
         end
         OP_CONTAINS: ok_in = found;
         default: ;
      endcase
      shift_back[0] = ins_here[0];
      shift_fwd[0]  = rem_at[0];
      for (int i = 1; i < Capacity; i++) begin
         shift_back[i] = ins_here[i] | shift_back[i-1];
         shift_fwd[i]  = rem_at[i]   | shift_fwd[i-1];
      end
      for (int i = 0; i < Capacity; i++) begin
         cell_in[i] = cell_ff[i];
         if (do_ins) begin
            if (ins_here[i])
               cell_in[i] = val_ff;
            else if (shift_back[i] && i > 0)
               cell_in[i] = cell_ff[(i > 0) ? i - 1 : 0];
         end else if (do_rem) begin
            if (shift_fwd[i] && i < Capacity - 1)
               cell_in[i] = cell_ff[(i < Capacity - 1) ? i + 1 : i];
         end
      end
      if (do_ins) begin
         ok_in    = 1'b1;
         count_in = count_ff + CountW'(1);
      end
      if (do_rem) begin
         ok_in    = 1'b1;
         count_in = count_ff - CountW'(1);
         if (op_type'(op_ff) != OP_REMOVE)
            for (int i = 0; i < Capacity; i++)
               if (rem_at[i]) pop_in = cell_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_operation;
         val_ff <= req_value;
      end
      if (cmd.execute) begin
         for (int i = 0; i < Capacity; i++) cell_ff[i] <= cell_in[i];
         ok_ff  <= ok_in;
         pop_ff <= pop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= cmd.execute;
         if (cmd.execute) count_ff <= count_in;
      end
   end

   assign stat.done  = done_ff;
   assign res_ok     = ok_ff;
   assign res_popped = pop_ff;
   assign res_count  = count_ff;

   `BSD_ASSERT_IMP(a_count_max, clock, reset, 1'b1, count_ff <= CountW'(Capacity),
      "count beyond capacity")
   `BSD_ASSERT_NEXT(a_done_follows, clock, reset, cmd.execute, done_ff,
      "done did not follow execute")
   `BSD_ASSERT_IMP(a_no_ins_full, clock, reset, cmd.execute && full, count_in <= count_ff,
      "insert into full store")
endmodule

>>> sv/bsd_ctrl.sv
`timescale 1ns / 1ps
`include "bounded_sorted_deque_defines.svh"
module bsd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output bsd_pkg::cmd_type   cmd,
   input  bsd_pkg::stat_type  stat
);
   import bsd_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WAIT} state_type;
   state_type state_ff;
   logic      valid_ff;

   assign req_stall   = (state_ff != S_IDLE) || (valid_ff && rsp_stall);
   assign cmd.capture = req_valid && !req_stall;
   assign cmd.execute = (state_ff == S_EXEC);
   assign rsp_valid   = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         if (valid_ff && !rsp_stall) valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (cmd.capture) state_ff <= S_EXEC;
            S_EXEC: state_ff <= S_WAIT;
            S_WAIT: begin
               valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `BSD_ASSERT_IMP(a_done_wait, clock, reset, stat.done, state_ff == S_WAIT,
      "done outside wait state")
   `BSD_ASSERT_NEXT(a_capture_exec, clock, reset, cmd.capture, state_ff == S_EXEC,
      "capture did not start execute")
   `BSD_ASSERT_IMP(a_no_overwrite, clock, reset, state_ff == S_WAIT, !valid_ff,
      "result overwritten")
endmodule

>>> sv/bounded_sorted_deque.sv
`timescale 1ns / 1ps
// channel   ports                                   direction
// req       req_valid req_stall req_operation       in
//           req_value
// rsp       rsp_valid rsp_stall rsp_ok              out
//           rsp_popped_value rsp_count
// Result valid after the accepted word is latched, then the cell row updates in S_EXEC, then S_WAIT sets valid.
// A new word is not accepted while the previous one is still in S_EXEC or S_WAIT.
// The whole row of cells compares and shifts together in the S_EXEC update.
// A new word is accepted once the previous result has been taken or is being taken.
// Reset clears the count and the handshake state; cell contents need no reset.
module bounded_sorted_deque (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_operation,
   input  logic signed [31:0]            req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_ok,
   output logic signed [31:0]            rsp_popped_value,
   output logic [bsd_pkg::CountW-1:0]    rsp_count
);
   import bsd_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   bsd_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .cmd, .stat
   );

   bsd_datapath u_dp (
      .clock, .reset, .cmd, .stat, .req_operation, .req_value,
      .res_ok(rsp_ok), .res_popped(rsp_popped_value), .res_count(rsp_count)
   );
endmodule
